FILE: rtl/core/rewl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rewl_pkg;

  localparam int unsigned TimeWidth   = 64;
  localparam int unsigned CountWidth  = 7;
  localparam int unsigned LimitWidth  = 8;
  localparam int unsigned SecondWidth = 16;
  localparam int unsigned TickWidth   = 24;
  localparam int unsigned WindowWidth = SecondWidth + TickWidth;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 16;

  localparam logic [TickWidth-1:0]   TICKS_PER_SECOND = 24'd10_000_000;
  localparam logic [CountWidth-1:0]  COUNT_FIELD_MAX  = 7'd127;
  localparam logic [LimitWidth-1:0]  LIMIT_COUNT_RST  = 8'd5;
  localparam logic [SecondWidth-1:0] LIMIT_SECS_RST   = 16'd60;

  typedef enum logic {
    OP_RECORD = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_LIMIT_COUNT   = 2'd0,
    CFG_LIMIT_SECONDS = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATE_IDLE  = 2'd0,
    STATE_SCAN  = 2'd1,
    STATE_DRAIN = 2'd2
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/core/recovery_event_window_limiter.sv
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window limiter for recovery events. A record transaction (op 0) stores its
// timestamp in a ring of HISTORY_DEPTH entries and gives no result; busy stays low. A
// query transaction (op 1) reads the ring one entry per cycle through its single read
// port, counting entries that are non-zero, not later than the given time and no older
// than limit_seconds * 10,000,000 ticks, so busy is high through the SCAN and DRAIN
// states and the result appears for one cycle on result_valid_o as busy falls. The next
// transaction can be taken in that cycle; until then a query holds off every new one.
// The receiver cannot stall it, so it must take every result when shown. No clearing
// pass follows reset: a fill count marks never-written entries as empty. Write the limit
// registers only while busy is low and no query is pending.
module recovery_event_window_limiter #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rewl_pkg::CfgIdxWidth-1:0]        cfg_index_i,
  input  wire logic [rewl_pkg::CfgWidth-1:0]           cfg_data_i,
  input  wire logic                                    start,
  output logic                                         busy,
  input  wire logic                                    op_i,
  input  wire logic [rewl_pkg::TimeWidth-1:0]          time_stamp_i,
  input  wire logic                                    include_current_i,
  output logic                                         result_valid_o,
  output logic      [rewl_pkg::CountWidth-1:0]         recent_count_o,
  output logic                                         limit_reached_o
);

  localparam int unsigned IdxWidth  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FillWidth = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CntWidth  = $clog2(HISTORY_DEPTH + 2);
  localparam int unsigned SumWidth  = (CntWidth > rewl_pkg::LimitWidth) ?
                                      CntWidth : rewl_pkg::LimitWidth;

  rewl_pkg::state_e                     state_q, state_d;
  logic [IdxWidth-1:0]                  idx_q, idx_d;
  logic                                 rd_valid_q, rd_live_q, rd_last_q;
  logic [rewl_pkg::TimeWidth-1:0]       now_q;
  logic                                 inc_q;
  logic [CntWidth-1:0]                  cnt_q, cnt_d;
  logic [rewl_pkg::WindowWidth-1:0]     window_q, window_d;
  logic [rewl_pkg::LimitWidth-1:0]      limit_count_q;
  logic [rewl_pkg::SecondWidth-1:0]     limit_seconds_q;
  logic                                 res_valid_q;
  logic [rewl_pkg::CountWidth-1:0]      recent_q;
  logic                                 reached_q;

  logic                                 accept, is_query, wr_en, rd_en, last_idx, live;
  logic [rewl_pkg::TimeWidth-1:0]       rd_data, age;
  logic [FillWidth-1:0]                 fill;
  logic                                 hit;
  logic [SumWidth-1:0]                  total;

  assign accept   = start && !busy;
  assign is_query = (op_i == rewl_pkg::OP_QUERY);
  assign wr_en    = accept && !is_query;
  assign last_idx = (idx_q == IdxWidth'(HISTORY_DEPTH - 1));
  assign live     = (FillWidth'(idx_q) < fill);
  assign busy     = (state_q != rewl_pkg::STATE_IDLE);

  rewl_ring #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (wr_en),
    .wr_data_i(time_stamp_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(idx_q),
    .rd_data_o(rd_data),
    .fill_o   (fill)
  );

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rd_en   = 1'b0;
    unique case (state_q)
      rewl_pkg::STATE_IDLE: begin
        if (accept && is_query) begin
          state_d = rewl_pkg::STATE_SCAN;
          idx_d   = '0;
        end
      end
      rewl_pkg::STATE_SCAN: begin
        rd_en = 1'b1;
        if (last_idx) begin
          state_d = rewl_pkg::STATE_DRAIN;
          idx_d   = '0;
        end else begin
          idx_d = idx_q + IdxWidth'(1);
        end
      end
      rewl_pkg::STATE_DRAIN: begin
        state_d = rewl_pkg::STATE_IDLE;
      end
      default: begin
        state_d = rewl_pkg::STATE_IDLE;
      end
    endcase
  end

  // compare one stored timestamp against the query time
  always_comb begin
    age   = now_q - rd_data;
    hit   = rd_valid_q && rd_live_q && (rd_data != '0) && (now_q >= rd_data) &&
            (age <= rewl_pkg::TimeWidth'(window_q));
    cnt_d = cnt_q;
    if (accept && is_query) begin
      cnt_d = '0;
    end else if (hit) begin
      cnt_d = cnt_q + CntWidth'(1);
    end
    total = SumWidth'(cnt_d) + SumWidth'(inc_q);
  end

  assign window_d = rewl_pkg::WindowWidth'(limit_seconds_q) *
                    rewl_pkg::WindowWidth'(rewl_pkg::TICKS_PER_SECOND);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= rewl_pkg::STATE_IDLE;
      idx_q           <= '0;
      rd_valid_q      <= 1'b0;
      rd_last_q       <= 1'b0;
      cnt_q           <= '0;
      res_valid_q     <= 1'b0;
      limit_count_q   <= rewl_pkg::LIMIT_COUNT_RST;
      limit_seconds_q <= rewl_pkg::LIMIT_SECS_RST;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_en;
      rd_last_q   <= rd_en && last_idx;
      cnt_q       <= cnt_d;
      res_valid_q <= rd_valid_q && rd_last_q;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          rewl_pkg::CFG_LIMIT_COUNT: begin
            limit_count_q <= cfg_data_i[rewl_pkg::LimitWidth-1:0];
          end
          rewl_pkg::CFG_LIMIT_SECONDS: begin
            limit_seconds_q <= cfg_data_i;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    window_q  <= window_d;
    rd_live_q <= live;
    if (accept && is_query) begin
      now_q <= time_stamp_i;
      inc_q <= include_current_i;
    end
    if (rd_valid_q && rd_last_q) begin
      recent_q  <= (total > SumWidth'(rewl_pkg::COUNT_FIELD_MAX)) ?
                   rewl_pkg::COUNT_FIELD_MAX : total[rewl_pkg::CountWidth-1:0];
      reached_q <= (total >= SumWidth'(limit_count_q));
    end
  end

  assign result_valid_o  = res_valid_q;
  assign recent_count_o  = recent_q;
  assign limit_reached_o = reached_q;

  a_query_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == rewl_pkg::OP_QUERY) |=> busy)
    else $error("query transaction did not start a scan");

  a_record_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == rewl_pkg::OP_RECORD) |=> !busy)
    else $error("record transaction raised busy");

  a_result_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == rewl_pkg::STATE_DRAIN))
    else $error("result strobe without a finished scan");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

endmodule

`default_nettype wire

FILE: rtl/core/rewl_ring.sv
`timescale 1ns / 1ps
`default_nettype none

module rewl_ring #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  input  wire logic                                      wr_en_i,
  input  wire logic [rewl_pkg::TimeWidth-1:0]            wr_data_i,
  input  wire logic                                      rd_en_i,
  input  wire logic [$clog2(HISTORY_DEPTH)-1:0]          rd_addr_i,
  output logic      [rewl_pkg::TimeWidth-1:0]            rd_data_o,
  output logic      [$clog2(HISTORY_DEPTH+1)-1:0]        fill_o
);

  localparam int unsigned IdxWidth  = $clog2(HISTORY_DEPTH);
  localparam int unsigned FillWidth = $clog2(HISTORY_DEPTH + 1);

  logic [rewl_pkg::TimeWidth-1:0] mem_q [HISTORY_DEPTH];
  logic [rewl_pkg::TimeWidth-1:0] rd_data_q;
  logic [IdxWidth-1:0]            wp_q, wp_d;
  logic [FillWidth-1:0]           fill_q, fill_d;

  // entries at or above the fill count have never been written and read as empty
  always_comb begin
    wp_d   = wp_q;
    fill_d = fill_q;
    if (wr_en_i) begin
      if (wp_q == IdxWidth'(HISTORY_DEPTH - 1)) begin
        wp_d = '0;
      end else begin
        wp_d = wp_q + IdxWidth'(1);
      end
      if (fill_q != FillWidth'(HISTORY_DEPTH)) begin
        fill_d = fill_q + FillWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else begin
      wp_q   <= wp_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign fill_o    = fill_q;

endmodule

`default_nettype wire
